>>> design/image_crc32_with_gap_fill_top_assert.svh
// assertion macros for the image crc block
`ifndef IMAGE_CRC32_WITH_GAP_FILL_TOP_ASSERT_SVH
`define IMAGE_CRC32_WITH_GAP_FILL_TOP_ASSERT_SVH

// same-cycle implication
`define ICRCGF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("icrcgf: same-cycle check failed");

// next-cycle implication
`define ICRCGF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("icrcgf: next-cycle check failed");

`endif

>>> design/icrcgf_pkg.sv
package icrcgf_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_APP_START    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_APP_MAX_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INFO_BASE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_OFFSET    = 2'd3;

  localparam logic [2:0] ST_CRC    = 3'd0;
  localparam logic [2:0] ST_GAP    = 3'd1;
  localparam logic [2:0] ST_INFO   = 3'd2;
  localparam logic [2:0] ST_RANGE  = 3'd3;
  localparam logic [2:0] ST_NOINFO = 3'd4;
  localparam logic [2:0] ST_BEHIND = 3'd5;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [7:0]  BYTE_FF  = 8'hFF;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CLASSIFY,
    S_DECIDE,
    S_RD_LO,
    S_RD_HI,
    S_CHECK,
    S_FILL,
    S_UPDATE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic       clear_step;
    logic       load_in;
    logic       classify;
    logic       info_wr;
    logic       rd_hi;
    logic       cap_lo;
    logic       gap_load;
    logic       fill_step;
    logic       update;
    logic       emit;
    logic       res_we;
    logic [2:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_info;
    logic is_app;
    logic id_missing;
    logic behind;
    logic ahead;
    logic gap_last;
    logic out_free;
  } stat_t;

  // one reflected crc-32 byte step, unrolled over the eight bits
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

>>> design/image_crc32_with_gap_fill_top.sv
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  address_i, data_byte_i
// out      output     out_valid_o/out_stall_i status_o, crc_value_o, image_size_o, info_length_o
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// info page and out-of-range words are settled in decide and go to emit; application words
// read both id bytes; accepted ones fill each skipped address (one crc byte step a cycle)
// after reset a clearing pass fills the info ram with 0xff
// one word in flight; the result sits in an output register while the next word is taken
// a stalled output only holds the block in its final state until the result leaves
`include "image_crc32_with_gap_fill_top_assert.svh"

module image_crc32_with_gap_fill_top #(
  parameter int unsigned INFO_PAGE_BYTES = 512
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [icrcgf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [31:0]                      address_i,
  input  logic [7:0]                       data_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [2:0]                       status_o,
  output logic [31:0]                      crc_value_o,
  output logic [31:0]                      image_size_o,
  output logic [9:0]                       info_length_o
);
  import icrcgf_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready_o = 1'b1;

  icrcgf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  icrcgf_dp #(
    .INFO_PAGE_BYTES (INFO_PAGE_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .address_i     (address_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .crc_value_o   (crc_value_o),
    .image_size_o  (image_size_o),
    .info_length_o (info_length_o),
    .cmd_i         (cmd),
    .st_o          (st)
  );

  // a taken word keeps the input side busy until its result is out
  `ICRCGF_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `ICRCGF_ASSERT_SAME(a_status_legal, out_valid_o, status_o <= ST_BEHIND)
  `ICRCGF_ASSERT_SAME(a_emit_from_busy, $rose(out_valid_o), $past(in_stall_o))

endmodule

>>> design/icrcgf_ram.sv
module icrcgf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/icrcgf_ctrl.sv
module icrcgf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  icrcgf_pkg::stat_t  st_i,
  output icrcgf_pkg::cmd_t   cmd_o
);
  import icrcgf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:    if (st_i.clear_last) state_d = S_IDLE;
      S_IDLE:     if (in_valid_i) state_d = S_CLASSIFY;
      S_CLASSIFY: state_d = S_DECIDE;
      S_DECIDE: begin
        if (st_i.is_info || !st_i.is_app) state_d = S_EMIT;
        else                              state_d = S_RD_LO;
      end
      S_RD_LO:    state_d = S_RD_HI;
      S_RD_HI:    state_d = S_CHECK;
      S_CHECK: begin
        if (st_i.id_missing || st_i.behind) state_d = S_EMIT;
        else if (st_i.ahead)                state_d = S_FILL;
        else                                state_d = S_UPDATE;
      end
      S_FILL:     if (st_i.gap_last) state_d = S_UPDATE;
      S_UPDATE:   state_d = S_EMIT;
      S_EMIT:     if (st_i.out_free) state_d = S_IDLE;
      default:    state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR:    cmd_o.clear_step = 1'b1;
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      S_CLASSIFY: cmd_o.classify = 1'b1;
      S_DECIDE: begin
        if (st_i.is_info) begin
          cmd_o.info_wr    = 1'b1;
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_INFO;
        end else if (!st_i.is_app) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_RANGE;
        end
      end
      S_RD_LO:    ;
      S_RD_HI: begin
        cmd_o.rd_hi  = 1'b1;
        cmd_o.cap_lo = 1'b1;
      end
      S_CHECK: begin
        cmd_o.res_we = 1'b1;
        if (st_i.id_missing) begin
          cmd_o.res_status = ST_NOINFO;
        end else if (st_i.behind) begin
          cmd_o.res_status = ST_BEHIND;
        end else if (st_i.ahead) begin
          cmd_o.res_status = ST_GAP;
          cmd_o.gap_load   = 1'b1;
        end else begin
          cmd_o.res_status = ST_CRC;
        end
      end
      S_FILL:     cmd_o.fill_step = 1'b1;
      S_UPDATE:   cmd_o.update = 1'b1;
      S_EMIT:     cmd_o.emit = st_i.out_free;
      default:    ;
    endcase
  end

endmodule

>>> design/icrcgf_dp.sv
module icrcgf_dp #(
  parameter int unsigned INFO_PAGE_BYTES = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [icrcgf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  input  logic [31:0]                         address_i,
  input  logic [7:0]                          data_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          status_o,
  output logic [31:0]                         crc_value_o,
  output logic [31:0]                         image_size_o,
  output logic [9:0]                          info_length_o,
  input  icrcgf_pkg::cmd_t                    cmd_i,
  output icrcgf_pkg::stat_t                   st_o
);
  import icrcgf_pkg::*;

  localparam int unsigned AW = $clog2(INFO_PAGE_BYTES);
  localparam int unsigned UW = $clog2(INFO_PAGE_BYTES + 1);

  // configuration
  logic [31:0] app_start_q, app_max_q, info_base_q;
  logic [8:0]  id_off_q;

  // running state
  logic [31:0]   crc_q, next_q, size_q;
  logic          started_q;
  logic [UW-1:0] info_used_q;
  logic [AW-1:0] clear_cnt_q;

  // per-word working registers
  logic [31:0]   addr_q, app_diff_q, gap_q;
  logic [7:0]    data_q, lo_q;
  logic          in_info_q, in_app_q;
  logic [AW-1:0] info_off_q;
  logic [2:0]    res_status_q;

  // output word
  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [31:0] crc_out_q, size_out_q;
  logic [9:0]  len_out_q;

  logic [32:0]   info_diff, app_diff;
  logic [UW-1:0] off_plus1;
  logic [31:0]   crc_next;
  logic          lo_oob, hi_oob;
  logic [7:0]    hi_byte;
  logic [AW-1:0] id_lo_addr, id_hi_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          out_free;

  assign info_diff = {1'b0, addr_q} - {1'b0, info_base_q};
  assign app_diff  = {1'b0, addr_q} - {1'b0, app_start_q};
  assign off_plus1 = UW'(info_off_q) + UW'(1);
  assign crc_next  = crc_byte(crc_q, cmd_i.fill_step ? BYTE_FF : data_q);

  // id bytes past the end of the store read as erased
  assign lo_oob     = ({23'h0, id_off_q} >= 32'(INFO_PAGE_BYTES));
  assign hi_oob     = (({23'h0, id_off_q} + 32'd1) >= 32'(INFO_PAGE_BYTES));
  assign id_lo_addr = AW'(id_off_q);
  assign id_hi_addr = AW'({1'b0, id_off_q} + 10'd1);
  assign hi_byte    = hi_oob ? BYTE_FF : ram_rdata;

  assign ram_we    = cmd_i.clear_step | cmd_i.info_wr;
  assign ram_waddr = cmd_i.clear_step ? clear_cnt_q : info_off_q;
  assign ram_wdata = cmd_i.clear_step ? BYTE_FF : data_q;
  assign ram_raddr = cmd_i.rd_hi ? id_hi_addr : id_lo_addr;

  icrcgf_ram #(
    .WIDTH (8),
    .DEPTH (INFO_PAGE_BYTES)
  ) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      app_start_q <= '0;
      app_max_q   <= '0;
      info_base_q <= '0;
      id_off_q    <= '0;
      crc_q       <= CRC_INIT;
      next_q      <= '0;
      size_q      <= '0;
      started_q   <= 1'b0;
      info_used_q <= '0;
      clear_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_APP_START:    app_start_q <= cfg_data_i;
          CFG_APP_MAX_SIZE: app_max_q   <= cfg_data_i;
          CFG_INFO_BASE:    info_base_q <= cfg_data_i;
          CFG_ID_OFFSET:    id_off_q    <= cfg_data_i[8:0];
        endcase
      end
      if (cmd_i.clear_step) begin
        clear_cnt_q <= clear_cnt_q + AW'(1);
      end
      if (cmd_i.info_wr && (off_plus1 > info_used_q)) begin
        info_used_q <= off_plus1;
      end
      if (cmd_i.fill_step || cmd_i.update) begin
        crc_q <= crc_next;
      end
      if (cmd_i.update) begin
        started_q <= 1'b1;
        next_q    <= addr_q + 32'd1;
        size_q    <= app_diff_q + 32'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      addr_q <= address_i;
      data_q <= data_byte_i;
    end
    if (cmd_i.classify) begin
      in_info_q  <= !info_diff[32] && (info_diff[31:0] < 32'(INFO_PAGE_BYTES));
      info_off_q <= info_diff[AW-1:0];
      in_app_q   <= !app_diff[32] && (app_diff[31:0] < app_max_q);
      app_diff_q <= app_diff[31:0];
    end
    if (cmd_i.cap_lo) begin
      lo_q <= lo_oob ? BYTE_FF : ram_rdata;
    end
    if (cmd_i.gap_load) begin
      gap_q <= addr_q - next_q;
    end else if (cmd_i.fill_step) begin
      gap_q <= gap_q - 32'd1;
    end
    if (cmd_i.res_we) begin
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.emit) begin
      status_q   <= res_status_q;
      crc_out_q  <= ~crc_q;
      size_out_q <= size_q;
      len_out_q  <= 10'(info_used_q);
    end
  end

  assign st_o.clear_last = (clear_cnt_q == AW'(INFO_PAGE_BYTES - 1));
  assign st_o.is_info    = in_info_q;
  assign st_o.is_app     = in_app_q;
  assign st_o.id_missing = ((lo_q == BYTE_FF) && (hi_byte == BYTE_FF)) || (info_used_q == '0);
  assign st_o.behind     = started_q && (addr_q < next_q);
  assign st_o.ahead      = started_q && (addr_q > next_q);
  assign st_o.gap_last   = (gap_q == 32'd1);
  assign st_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign crc_value_o   = crc_out_q;
  assign image_size_o  = size_out_q;
  assign info_length_o = len_out_q;

endmodule

>>> verif/tb_image_crc32_with_gap_fill_top.sv
module tb_image_crc32_with_gap_fill_top;
  import icrcgf_pkg::*;

  localparam int unsigned INFO_BYTES   = 512;
  localparam int unsigned RAND_WORDS   = 1850;
  localparam int unsigned MAX_FILL     = 512;
  localparam int unsigned CYCLE_LIMIT  = 6000000;
  localparam int unsigned SETTLE_TICKS = 32;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] crc;
    logic [31:0] size;
    logic [9:0]  info_len;
  } image_result_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_WORD,
    ROW_KNOWN
  } row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          word;
    logic [7:0]           data;
    logic [2:0]           x_status;
    logic [31:0]          x_crc;
    logic [31:0]          x_size;
    logic [9:0]           x_ilen;
  } dir_row_t;

  // known rows carry their result; the rest go through the tracker
  localparam dir_row_t DIR_TAB [35] = '{
    '{ROW_KNOWN, '0, 32'h0000_0200, 8'h12, ST_RANGE, 32'h0, 32'h0, 10'd0},
    '{ROW_KNOWN, '0, 32'h0000_0000, 8'h00, ST_INFO, 32'h0, 32'h0, 10'd1},
    '{ROW_KNOWN, '0, 32'h0000_01FF, 8'hFF, ST_INFO, 32'h0, 32'h0, 10'd512},
    '{ROW_CFG, CFG_APP_START, 32'hFFFF_FF00, 8'h00, '0, '0, '0, '0},
    '{ROW_CFG, CFG_APP_MAX_SIZE, 32'hFFFF_FFFF, 8'h00, '0, '0, '0, '0},
    '{ROW_CFG, CFG_INFO_BASE, 32'hFFFF_FFF8, 8'h00, '0, '0, '0, '0},
    '{ROW_CFG, CFG_ID_OFFSET, 32'h0000_01FF, 8'h00, '0, '0, '0, '0},
    '{ROW_KNOWN, '0, 32'hFFFF_FF00, 8'h5A, ST_NOINFO, 32'h0, 32'h0, 10'd512},
    '{ROW_CFG, CFG_ID_OFFSET, 32'hFFFF_FE00, 8'h00, '0, '0, '0, '0},
    '{ROW_KNOWN, '0, 32'hFFFF_FEFF, 8'h00, ST_RANGE, 32'h0, 32'h0, 10'd512},
    '{ROW_WORD, '0, 32'hFFFF_FF00, 8'h00, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'hFFFF_FF03, 8'hC3, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'hFFFF_FF01, 8'h99, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'hFFFF_FFF8, 8'h77, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'hFFFF_FFF7, 8'h81, '0, '0, '0, '0},
    '{ROW_CFG, CFG_INFO_BASE, 32'h0000_1000, 8'h00, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'hFFFF_FFFF, 8'h3C, '0, '0, '0, '0},
    '{ROW_CFG, CFG_APP_START, 32'h0000_0000, 8'h00, '0, '0, '0, '0},
    '{ROW_CFG, CFG_APP_MAX_SIZE, 32'h0000_0000, 8'h00, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'h0000_0000, 8'hA5, '0, '0, '0, '0},
    '{ROW_CFG, CFG_APP_MAX_SIZE, 32'h0000_0800, 8'h00, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'h0000_0000, 8'h00, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'h0000_0800, 8'h11, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'h0000_07FF, 8'hFF, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'h0000_1000, 8'hFF, '0, '0, '0, '0},
    '{ROW_CFG, CFG_APP_MAX_SIZE, 32'hFFFF_FFFF, 8'h00, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'h0000_0800, 8'h11, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'h0000_1001, 8'h00, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'h0000_0800, 8'h11, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'h0000_0700, 8'h6E, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'hFFFF_FFFF, 8'h42, '0, '0, '0, '0},
    '{ROW_CFG, CFG_ID_OFFSET, 32'h0000_01FE, 8'h00, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'h0000_0801, 8'hE7, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'h0000_11FE, 8'h01, '0, '0, '0, '0},
    '{ROW_WORD, '0, 32'h0000_0801, 8'hFE, '0, '0, '0, '0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [31:0]          address_i = '0;
  logic [7:0]           data_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [2:0]           status_o;
  logic [31:0]          crc_value_o;
  logic [31:0]          image_size_o;
  logic [9:0]           info_length_o;

  // tracked block state and register copies
  logic [31:0] app_start_q = '0;
  logic [31:0] app_size_q = '0;
  logic [31:0] info_base_q = '0;
  logic [8:0]  id_off_q = '0;
  logic [31:0] crc_q = CRC_INIT;
  logic [31:0] next_q = '0;
  logic        started_q = 1'b0;
  logic [7:0]  page_q [INFO_BYTES];
  logic [9:0]  info_used_q = '0;
  logic [31:0] size_q = '0;

  image_result_t pending_results [$];
  int unsigned   mismatches = 0;
  int unsigned   rand_words = 0;
  int unsigned   stall_left = 0;
  int unsigned   cycle_count = 0;
  bit            idle_en = 1'b1;

  image_crc32_with_gap_fill_top #(
    .INFO_PAGE_BYTES(INFO_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .address_i    (address_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .crc_value_o  (crc_value_o),
    .image_size_o (image_size_o),
    .info_length_o(info_length_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // reflected crc-32, data fed in one bit at a time
  function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] s;
    s = c;
    for (int i = 0; i < 8; i++) begin
      s = {1'b0, s[31:1]} ^ ((s[0] ^ b[i]) ? CRC_POLY : 32'h0);
    end
    return s;
  endfunction

  function automatic logic [7:0] page_byte(input logic [9:0] off);
    return (off < INFO_BYTES) ? page_q[off[8:0]] : BYTE_FF;
  endfunction

  function automatic logic [2:0] classify_word(input logic [31:0] a);
    logic [15:0] dev_id;
    if (a >= info_base_q && a - info_base_q < INFO_BYTES) begin
      return ST_INFO;
    end
    // window end taken in 33 bits so it clips rather than wraps
    if (a < app_start_q || {1'b0, a} + 33'd1 > {1'b0, app_start_q} + {1'b0, app_size_q}) begin
      return ST_RANGE;
    end
    dev_id = {page_byte({1'b0, id_off_q} + 10'd1), page_byte({1'b0, id_off_q})};
    if (dev_id == 16'hFFFF || info_used_q == '0) begin
      return ST_NOINFO;
    end
    if (started_q && a < next_q) begin
      return ST_BEHIND;
    end
    if (started_q && a > next_q) begin
      return ST_GAP;
    end
    return ST_CRC;
  endfunction

  function automatic image_result_t track_word(input logic [31:0] a, input logic [7:0] d);
    image_result_t r;
    logic [31:0]   off;
    logic [31:0]   fill;
    r.status = classify_word(a);
    if (r.status == ST_INFO) begin
      off = a - info_base_q;
      page_q[off[8:0]] = d;
      if (off + 32'd1 > {22'h0, info_used_q}) begin
        info_used_q = off[9:0] + 10'd1;
      end
    end else if (r.status == ST_CRC || r.status == ST_GAP) begin
      if (r.status == ST_GAP) begin
        fill = a - next_q;
        while (fill != 0) begin
          crc_q = crc_feed(crc_q, BYTE_FF);
          fill--;
        end
      end
      crc_q     = crc_feed(crc_q, d);
      started_q = 1'b1;
      next_q    = a + 32'd1;
      size_q    = next_q - app_start_q;
    end
    r.crc      = ~crc_q;
    r.size     = size_q;
    r.info_len = info_used_q;
    return r;
  endfunction

  // keeps random words from asking for an endless gap fill
  function automatic logic [31:0] tame_addr(input logic [31:0] a);
    if (classify_word(a) == ST_GAP && a - next_q > MAX_FILL) begin
      return next_q;
    end
    return a;
  endfunction

  task automatic send_word(input logic [31:0] a, input logic [7:0] d,
                           input bit use_typed = 1'b0, input image_result_t typed = '0);
    image_result_t r;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    address_i   <= a;
    data_byte_i <= d;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    r = track_word(a, d);
    pending_results.push_back(use_typed ? typed : r);
  endtask

  task automatic send_rand(input logic [31:0] a, input logic [7:0] d);
    send_word(tame_addr(a), d);
    rand_words++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_APP_START:    app_start_q = v;
      CFG_APP_MAX_SIZE: app_size_q = v;
      CFG_INFO_BASE:    info_base_q = v;
      CFG_ID_OFFSET:    id_off_q = v[8:0];
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase();
    logic [31:0] start_v;
    logic [31:0] size_v;
    logic [31:0] base_v;
    logic [31:0] id_word;
    logic [31:0] a;
    logic [8:0]  id_v;
    int unsigned pick;
    idle_en = (rand_words + 250 < RAND_WORDS) && ($urandom_range(0, 3) != 0);
    drain();
    // new windows close to the fill point so gaps stay short
    case ($urandom_range(0, 3))
      0:       start_v = next_q - $urandom_range(0, 64);
      1:       start_v = next_q;
      default: start_v = next_q + $urandom_range(1, 300);
    endcase
    case ($urandom_range(0, 11))
      0:       size_v = 32'h0;
      1:       size_v = 32'hFFFF_FFFF;
      default: size_v = $urandom_range(16, 2048);
    endcase
    case ($urandom_range(0, 9))
      0:       base_v = 32'hFFFF_FFFF;
      1:       base_v = 32'h0;
      2:       base_v = start_v + $urandom_range(0, 255);
      3, 4:    base_v = $urandom;
      default: base_v = start_v + 32'h0001_0000 + $urandom_range(0, 32'hFFFF);
    endcase
    case ($urandom_range(0, 9))
      0:       id_v = 9'd0;
      1:       id_v = 9'd510;
      2:       id_v = 9'd511;
      default: id_v = 9'($urandom_range(0, 511));
    endcase
    id_word      = $urandom;
    id_word[8:0] = id_v;
    write_reg(CFG_APP_START, start_v);
    write_reg(CFG_APP_MAX_SIZE, size_v);
    write_reg(CFG_INFO_BASE, base_v);
    write_reg(CFG_ID_OFFSET, id_word);
    cfg_valid_i <= 1'b0;

    // device id first, now and then left to what the page already holds
    if ($urandom_range(0, 5) != 0) begin
      send_rand(base_v + 32'(id_v), 8'($urandom_range(0, 255)));
      send_rand(base_v + 32'(id_v) + 32'd1,
                ($urandom_range(0, 7) == 0) ? BYTE_FF : 8'($urandom_range(0, 254)));
    end
    repeat ($urandom_range(0, 6)) send_rand(base_v + $urandom_range(0, 511), 8'($urandom));

    repeat ($urandom_range(16, 96)) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        a = next_q;
      end else if (pick < 75) begin
        a = next_q + $urandom_range(1, 8);
      end else if (pick < 78) begin
        a = next_q + $urandom_range(9, 300);
      end else if (pick < 85) begin
        a = next_q - $urandom_range(1, 16);
      end else if (pick < 88) begin
        a = start_v - $urandom_range(1, 8);
      end else if (pick < 90) begin
        a = start_v + size_v + $urandom_range(0, 8) - 32'd2;
      end else if (pick < 95) begin
        a = base_v + $urandom_range(0, 520);
      end else begin
        a = $urandom;
      end
      send_rand(a, 8'($urandom_range(0, 255)));
    end
  endtask

  // result side: stall bursts and the word-by-word compare
  always @(posedge clk_i) begin : result_check
    image_result_t want;
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16);
    end
    if (out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with none pending, status %0d", status_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status_o);
          mismatches++;
        end
        if (crc_value_o !== want.crc) begin
          $error("crc_value expected %h actual %h", want.crc, crc_value_o);
          mismatches++;
        end
        if (image_size_o !== want.size) begin
          $error("image_size expected %h actual %h", want.size, image_size_o);
          mismatches++;
        end
        if (info_length_o !== want.info_len) begin
          $error("info_length expected %0d actual %0d", want.info_len, info_length_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= (stall_left != 0);
  end

  initial begin : watchdog
    do begin
      @(posedge clk_i);
      cycle_count++;
    end while (cycle_count < CYCLE_LIMIT);
    $display("FAIL image_crc32_with_gap_fill_top");
    $finish;
  end

  initial begin : stimulus
    dir_row_t      row;
    image_result_t typed;
    bit            cfg_open;
    cfg_open = 1'b0;
    foreach (page_q[i]) page_q[i] = BYTE_FF;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_TAB[i]) begin
      row = DIR_TAB[i];
      if (row.kind == ROW_CFG) begin
        if (!cfg_open) begin
          drain();
        end
        write_reg(row.idx, row.word);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid_i <= 1'b0;
          cfg_open = 1'b0;
        end
        typed = '{row.x_status, row.x_crc, row.x_size, row.x_ilen};
        send_word(row.word, row.data, row.kind == ROW_KNOWN, typed);
      end
    end

    while (rand_words < RAND_WORDS) run_phase();

    drain();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS image_crc32_with_gap_fill_top");
    end else begin
      $display("FAIL image_crc32_with_gap_fill_top");
    end
    $finish;
  end

endmodule
